// ----- rtl/pgwc_pkg.sv -----
// Shared widths and codes for the PCM gain and width converter.
package pgwc_pkg;

    localparam int SAMPLE_W       = 32;
    localparam int GAIN_W         = 17;
    localparam int GAIN_FRAC_BITS = 16;
    localparam int CHAN_W         = 16;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 17;

    localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NARROW        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_GAIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_GAIN    = 3'd4;

    localparam logic [1:0] WCODE_16 = 2'd0;
    localparam logic [1:0] WCODE_24 = 2'd1;

endpackage

// ----- rtl/pgwc_in_if.sv -----
// Input sample channel: valid, ready, the raw sample payload and a packet start flag.
interface pgwc_in_if import pgwc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] raw_sample;
    logic                packet_start;

    modport source (output valid, output raw_sample, output packet_start, input ready);
    modport sink   (input valid, input raw_sample, input packet_start, output ready);
endinterface

// ----- rtl/pgwc_out_if.sv -----
// Result channel: valid, ready, the converted sample payload and a right-gain flag.
interface pgwc_out_if import pgwc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] out_sample;
    logic                used_right_gain;

    modport source (output valid, output out_sample, output used_right_gain, input ready);
    modport sink   (input valid, input out_sample, input used_right_gain, output ready);
endinterface

// ----- rtl/pcm_gain_width_converter_core.sv -----
// PCM gain and width converter core: channel gain select, scaling and width shift.
// Each input transfer passes through three registered stages before the result is valid.
// Throughput: one sample per cycle; stages collapse bubbles, so a stalled result
// blocks input only when all three stages are full.
// Reset (rst_n low, asynchronous): pipeline empty, channel position 0,
// registers to 16-bit input, no narrowing, 2 channels, unity gains.
module pcm_gain_width_converter_core
    import pgwc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    pgwc_in_if.sink               sample_ch,
    pgwc_out_if.source            result_ch
);

    localparam int PROD_W = SAMPLE_W + GAIN_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam logic [SAMPLE_W-1:0] UNITY      = SAMPLE_W'(1) << GAIN_FRAC_BITS;
    localparam logic [SUM_W-1:0]    ROUND_HALF = SUM_W'(1) << (GAIN_FRAC_BITS - 1);

    logic [1:0]        in_width_code_reg;
    logic              narrow_to_16_reg;
    logic [CHAN_W-1:0] channel_count_reg;
    logic [GAIN_W-1:0] gain_l_reg;
    logic [GAIN_W-1:0] gain_r_reg;
    logic [CHAN_W-1:0] pos_reg;
    logic [CHAN_W-1:0] pos_next;

    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic load_1;
    logic load_2;
    logic load_3;
    logic in_xfer;

    logic [SAMPLE_W-1:0] mag1_reg;
    logic                neg1_reg;
    logic [GAIN_W-1:0]   gain1_reg;
    logic                bypass1_reg;
    logic                right1_reg;

    logic [SAMPLE_W-1:0] mag2_reg;
    logic                neg2_reg;
    logic                right2_reg;

    logic [SAMPLE_W-1:0] out_sample_reg;
    logic                right3_reg;

    logic [CHAN_W-1:0]   count_eff;
    logic [CHAN_W-1:0]   pos_eff;
    logic [CHAN_W:0]     pos_inc;
    logic                right_now;
    logic [SAMPLE_W-1:0] sext;
    logic [SAMPLE_W-1:0] mag_now;
    logic [GAIN_W-1:0]   gain_now;
    logic [PROD_W-1:0]   prod;
    logic [SUM_W-1:0]    rounded;
    logic [SAMPLE_W-1:0] scaled;
    logic [SAMPLE_W-1:0] signed_val;
    logic [SAMPLE_W-1:0] shifted;
    logic [SAMPLE_W-1:0] masked;

    assign load_3  = !v3_reg || result_ch.ready;
    assign load_2  = !v2_reg || load_3;
    assign load_1  = !v1_reg || load_2;
    assign in_xfer = sample_ch.valid && load_1;

    assign sample_ch.ready           = load_1;
    assign result_ch.valid           = v3_reg;
    assign result_ch.out_sample      = out_sample_reg;
    assign result_ch.used_right_gain = right3_reg;

    always_comb
    begin
        count_eff = (channel_count_reg == '0) ? CHAN_W'(1) : channel_count_reg;
        pos_eff   = sample_ch.packet_start ? '0 : pos_reg;
        if (pos_eff >= count_eff)
        begin
            pos_eff = '0;
        end
        right_now = (pos_eff == CHAN_W'(1));
        pos_inc   = {1'b0, pos_eff} + (CHAN_W + 1)'(1);
        if (pos_inc >= {1'b0, count_eff})
        begin
            pos_next = '0;
        end
        else
        begin
            pos_next = pos_inc[CHAN_W-1:0];
        end
    end

    always_comb
    begin
        case (in_width_code_reg)
            WCODE_16: sext = {{16{sample_ch.raw_sample[15]}}, sample_ch.raw_sample[15:0]};
            WCODE_24: sext = {{8{sample_ch.raw_sample[23]}}, sample_ch.raw_sample[23:0]};
            default:  sext = sample_ch.raw_sample;
        endcase
        mag_now  = sext[SAMPLE_W-1] ? (~sext + SAMPLE_W'(1)) : sext;
        gain_now = right_now ? gain_r_reg : gain_l_reg;
    end

    assign prod    = mag1_reg * gain1_reg;
    assign rounded = {1'b0, prod} + ROUND_HALF;
    assign scaled  = SAMPLE_W'(rounded >> GAIN_FRAC_BITS);

    always_comb
    begin
        signed_val = neg2_reg ? (~mag2_reg + SAMPLE_W'(1)) : mag2_reg;
        shifted    = signed_val;
        if (narrow_to_16_reg)
        begin
            case (in_width_code_reg)
                WCODE_16: shifted = signed_val;
                WCODE_24: shifted = SAMPLE_W'($signed(signed_val) >>> 8);
                default:  shifted = SAMPLE_W'($signed(signed_val) >>> 16);
            endcase
            masked = {16'd0, shifted[15:0]};
        end
        else
        begin
            case (in_width_code_reg)
                WCODE_16: masked = {16'd0, shifted[15:0]};
                WCODE_24: masked = {8'd0, shifted[23:0]};
                default:  masked = shifted;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_width_code_reg <= WCODE_16;
            narrow_to_16_reg  <= 1'b0;
            channel_count_reg <= CHAN_W'(2);
            gain_l_reg        <= GAIN_W'(65536);
            gain_r_reg        <= GAIN_W'(65536);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IN_WIDTH:      in_width_code_reg <= cfg_data[1:0];
                REG_NARROW:        narrow_to_16_reg  <= cfg_data[0];
                REG_CHANNEL_COUNT: channel_count_reg <= cfg_data[CHAN_W-1:0];
                REG_LEFT_GAIN:     gain_l_reg        <= cfg_data[GAIN_W-1:0];
                REG_RIGHT_GAIN:    gain_r_reg        <= cfg_data[GAIN_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                pos_reg <= pos_next;
            end
            if (load_1)
            begin
                v1_reg <= sample_ch.valid;
            end
            if (load_2)
            begin
                v2_reg <= v1_reg;
            end
            if (load_3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_1)
        begin
            mag1_reg    <= mag_now;
            neg1_reg    <= sext[SAMPLE_W-1];
            gain1_reg   <= gain_now;
            bypass1_reg <= (SAMPLE_W'(gain_now) >= UNITY);
            right1_reg  <= right_now;
        end
        if (load_2)
        begin
            mag2_reg   <= bypass1_reg ? mag1_reg : scaled;
            neg2_reg   <= neg1_reg;
            right2_reg <= right1_reg;
        end
        if (load_3)
        begin
            out_sample_reg <= masked;
            right3_reg     <= right2_reg;
        end
    end

    a_start_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && sample_ch.packet_start) |=> (pos_reg == '0 || pos_reg == CHAN_W'(1)))
        else $error("channel position not restarted by packet start");

    a_start_left: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && sample_ch.packet_start) |=> (v1_reg && !right1_reg))
        else $error("packet start sample took right gain");

    a_hold_full: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && v3_reg && !result_ch.ready) |=> (v2_reg && v3_reg))
        else $error("stalled pipeline dropped an item");

endmodule
